[sv/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is low
`define DH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never be seen outside reset
`define DH_ASSERT_NEVER(label, clk, rst_n, cond) \
  `DH_ASSERT(label, clk, rst_n, !(cond))

`endif

[sv/dhssm_pkg.sv]
package dhssm_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_PHASE   = 2'd0,
    OP_SECTOR  = 2'd1,
    OP_LOAD    = 2'd2,
    OP_REMOUNT = 2'd3
  } opcode_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_CLUSTER_SHIFT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_BLOCK   = 1'd1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [2:0] ClusterShiftRst = 3'd6;

  // stream widths
  localparam int unsigned SDataW = 40;
  localparam int unsigned SUserW = 2;
  localparam int unsigned MDataW = 56;
  localparam int unsigned MUserW = 2;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned ClusterW      = 28;
  localparam int unsigned LsecW         = 10;

  // signed step nibbles, high nibble for even picks
  localparam logic [7:0] StepNibbles [4] = '{8'h0f, 8'hed, 8'h03, 8'h21};

  localparam logic [7:0] PosWrapLimit = 8'd196;
  localparam logic [7:0] PosMax       = 8'd139;

endpackage

[sv/disk_head_stepper_sector_mapper_top.sv]
// Floppy head stepper and sector mapper. Each input word (kind on tuser) is
// a phase sample, a sector advance, a cluster table load or a remount, and
// gives exactly one result word: head position in quarter tracks, sector,
// whole track, and for a sector advance the storage block found through the
// cluster table (flags on tuser: bit 0 block valid, bit 1 index error).
// One word is taken every cycle unless the result side stalls; each result
// passes the input register, the table read register (set by the registered
// cluster table read) and the output register. Backpressure on the result
// side stalls the whole pipe. The cluster table starts all zero through
// per-entry valid bits, so no clearing pass is run. The user must write
// configuration through the cfg channel only while idle (not enforced).
module disk_head_stepper_sector_mapper_top #(
  parameter int unsigned TABLE_DEPTH = dhssm_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dhssm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dhssm_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // phase_lines[3:0], entry_index[7:4], cluster_value[35:8], zero pad
  input  logic [dhssm_pkg::SDataW-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  logic [dhssm_pkg::SUserW-1:0]   s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // quarter_track[7:0], sector_number[11:8], whole_track[17:12],
  // block_address[49:18], zero pad
  output logic [dhssm_pkg::MDataW-1:0]   m_axis_tdata,
  // block_valid[0], index_error[1]
  output logic [dhssm_pkg::MUserW-1:0]   m_axis_tuser
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EntW  = (AddrW > 4) ? AddrW : 4;
  localparam int unsigned LsecW = dhssm_pkg::LsecW;
  localparam int unsigned CluW  = dhssm_pkg::ClusterW;

  // handshakes and stage flow
  logic out_rdy, s2_rdy, s1_rdy;
  logic s_fire, s1_fire, cfg_fire;

  // configuration registers
  logic [2:0]  shift_q;
  logic [31:0] first_q;

  // drive state
  logic [7:0] head_q, head_d;
  logic [3:0] sec_q, sec_d;
  logic [3:0] prev_q, prev_d;

  // input register
  logic                  s1_vld_q;
  dhssm_pkg::opcode_e    s1_op_q;
  logic [3:0]            s1_lines_q;
  logic [3:0]            s1_entry_q;
  logic [CluW-1:0]       s1_cluster_q;

  // cluster table and its valid bits
  logic [CluW-1:0]        tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_q;
  logic                   tbl_we;
  logic [AddrW-1:0]       tbl_waddr, tbl_raddr;

  // stage one results
  logic [LsecW-1:0] lsec, lclu;
  logic             in_range, load_ok;
  logic [EntW-1:0]  ent_ext;
  logic [2:0]       pick, off;
  logic             one_hot;
  logic [7:0]       step_byte, step_ext, pos_sum, pos_new;
  logic [3:0]       step_nib;
  logic             s1_sector_ok, s1_err;

  // middle stage
  logic             s2_vld_q;
  logic [7:0]       s2_head_q;
  logic [3:0]       s2_sec_q;
  logic [LsecW-1:0] s2_lsec_q;
  logic             s2_ok_q, s2_err_q;
  logic [CluW-1:0]  s2_rd_q;
  logic             s2_rd_vld_q;

  logic [31:0] cluster, mask, addr;

  // output register
  logic                       out_vld_q;
  logic [dhssm_pkg::MDataW-1:0] out_data_q;
  logic [dhssm_pkg::MUserW-1:0] out_user_q;

  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign s2_rdy        = !s2_vld_q || out_rdy;
  assign s1_rdy        = !s1_vld_q || s2_rdy;
  assign s_axis_tready = s1_rdy;
  assign s_fire        = s_axis_tvalid && s1_rdy;
  assign s1_fire       = s1_vld_q && s2_rdy;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= dhssm_pkg::ClusterShiftRst;
      first_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        dhssm_pkg::CFG_CLUSTER_SHIFT: shift_q <= cfg_data_i[2:0];
        dhssm_pkg::CFG_FIRST_BLOCK:   first_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_op_q      <= dhssm_pkg::opcode_e'(s_axis_tuser[1:0]);
      s1_lines_q   <= s_axis_tdata[3:0];
      s1_entry_q   <= s_axis_tdata[7:4];
      s1_cluster_q <= s_axis_tdata[35:8];
    end
  end

  // head step decode
  always_comb begin
    one_hot = 1'b1;
    unique case (s1_lines_q)
      4'b1000: off = 3'd2;
      4'b0100: off = 3'd4;
      4'b0010: off = 3'd6;
      4'b0001: off = 3'd0;
      default: begin
        off     = 3'd0;
        one_hot = 1'b0;
      end
    endcase
    pick      = off + head_q[2:0];
    step_byte = dhssm_pkg::StepNibbles[pick[2:1]];
    step_nib  = pick[0] ? step_byte[3:0] : step_byte[7:4];
    step_ext  = {{4{step_nib[3]}}, step_nib};
    pos_sum   = head_q + step_ext;
    // negative wrap to zero, top end clamped
    if (pos_sum > dhssm_pkg::PosWrapLimit) begin
      pos_new = '0;
    end else if (pos_sum > dhssm_pkg::PosMax) begin
      pos_new = dhssm_pkg::PosMax;
    end else begin
      pos_new = pos_sum;
    end
  end

  assign ent_ext   = EntW'(s1_entry_q);
  assign load_ok   = 32'(ent_ext) < 32'(TABLE_DEPTH);
  assign tbl_waddr = ent_ext[AddrW-1:0];

  // item update
  always_comb begin
    head_d       = head_q;
    sec_d        = sec_q;
    prev_d       = prev_q;
    tbl_we       = 1'b0;
    s1_sector_ok = 1'b0;
    s1_err       = 1'b0;
    lsec         = {head_q[7:2], sec_q};
    lclu         = '0;
    in_range     = 1'b0;
    unique case (s1_op_q)
      dhssm_pkg::OP_PHASE: begin
        if (s1_lines_q != prev_q) begin
          prev_d = s1_lines_q;
          if (one_hot) begin
            head_d = pos_new;
          end
        end
      end
      dhssm_pkg::OP_SECTOR: begin
        sec_d        = sec_q + 4'd1;
        lsec         = {head_q[7:2], sec_d};
        lclu         = lsec >> shift_q;
        in_range     = 32'(lclu) < 32'(TABLE_DEPTH);
        s1_sector_ok = in_range;
        s1_err       = !in_range;
      end
      dhssm_pkg::OP_LOAD: begin
        tbl_we = s1_fire && load_ok;
        s1_err = !load_ok;
      end
      dhssm_pkg::OP_REMOUNT: begin
        head_d = '0;
        sec_d  = '0;
      end
      default: ;
    endcase
  end

  assign tbl_raddr = lclu[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      sec_q  <= '0;
      prev_q <= '0;
    end else if (s1_fire) begin
      head_q <= head_d;
      sec_q  <= sec_d;
      prev_q <= prev_d;
    end
  end

  // cluster table: write from a load, registered read for a sector advance
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= s1_cluster_q;
    end
    if (s1_fire) begin
      s2_rd_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
    end else if (tbl_we) begin
      tbl_vld_q[tbl_waddr] <= 1'b1;
    end
  end

  // middle stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_head_q   <= head_d;
      s2_sec_q    <= sec_d;
      s2_lsec_q   <= lsec;
      s2_ok_q     <= s1_sector_ok;
      s2_err_q    <= s1_err;
      s2_rd_vld_q <= tbl_vld_q[tbl_raddr];
    end
  end

  // block address: ((entry - 2) << shift) + first block + sector in cluster
  assign cluster = s2_rd_vld_q ? 32'(s2_rd_q) : 32'd0;
  assign mask    = (32'd1 << shift_q) - 32'd1;
  assign addr    = ((cluster - 32'd2) << shift_q) + first_q + (32'(s2_lsec_q) & mask);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && out_rdy) begin
      out_data_q <= {6'd0, (s2_ok_q ? addr : 32'd0), s2_head_q[7:2], s2_sec_q, s2_head_q};
      out_user_q <= {s2_err_q, s2_ok_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[sv/dhssm_checker.sv]
`include "assert_macros.svh"

module dhssm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [dhssm_pkg::MDataW-1:0]   m_axis_tdata,
  input logic [dhssm_pkg::MUserW-1:0]   m_axis_tuser
);

  logic                                         out_stall;
  logic                                         flag_clash;
  logic [dhssm_pkg::MDataW+dhssm_pkg::MUserW-1:0] out_word;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_word   = {m_axis_tuser, m_axis_tdata};
  assign flag_clash = (m_axis_tuser[0] && m_axis_tuser[1]) ||
                      (!m_axis_tuser[0] && (m_axis_tdata[49:18] != 32'd0));

  // stalled result holds
  `DH_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> $stable(out_word))

  // head never beyond the last quarter track
  `DH_ASSERT(a_track_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[7:0] <= dhssm_pkg::PosMax)

  // whole track follows the quarter track
  `DH_ASSERT(a_whole_track, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[17:12] == m_axis_tdata[7:2])

  // no address without a valid block, never both flags
  `DH_ASSERT_NEVER(a_flags, clk_i, rst_ni, m_axis_tvalid && flag_clash)

endmodule

bind disk_head_stepper_sector_mapper_top dhssm_checker u_dhssm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
